>>> hdl/nrd_pkg.sv
package nrd_pkg;

    // Field and register widths
    localparam int NODE_ID_BITS_DEF = 8;
    localparam int SIDE_BITS        = 8;
    localparam int HOP_BITS         = 8;
    localparam int DIR_BITS         = 3;
    localparam int TOPO_BITS        = 2;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 8;

    // Output direction codes
    typedef enum logic [DIR_BITS-1:0] {
        DIR_ARRIVED = 3'd0,
        DIR_LEFT    = 3'd1,
        DIR_RIGHT   = 3'd2,
        DIR_TOP     = 3'd3,
        DIR_BOTTOM  = 3'd4,
        DIR_ANY_X   = 3'd5,
        DIR_ANY_Y   = 3'd6
    } dir_t;

    // Topology codes; the spare code routes nowhere
    typedef enum logic [TOPO_BITS-1:0] {
        TOPO_RING  = 2'd0,
        TOPO_TORUS = 2'd1,
        TOPO_MESH  = 2'd2
    } topo_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TOPOLOGY   = 1'b0,
        CFG_SIDE_NODES = 1'b1
    } cfg_idx_t;

    localparam logic [TOPO_BITS-1:0] TOPO_RESET = TOPO_MESH;
    localparam logic [SIDE_BITS-1:0] SIDE_RESET = 8'd4;

    // One routing decision
    typedef struct packed {
        dir_t                dir;
        logic [HOP_BITS-1:0] hops;
    } route_t;

endpackage

>>> hdl/nrd_if.sv
// Request word: the node holding the packet and its destination
interface nrd_req_if import nrd_pkg::*; #(
    parameter int ID_BITS = NODE_ID_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] current_node;
    logic [ID_BITS-1:0] target_node;

    modport source (output valid, output current_node, output target_node, input ready);
    modport sink   (input valid, input current_node, input target_node, output ready);
endinterface

// Response word: chosen direction and hops left on that axis
interface nrd_rsp_if import nrd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DIR_BITS-1:0] route_dir;
    logic [HOP_BITS-1:0] hop_distance;

    modport source (output valid, output route_dir, output hop_distance, input ready);
    modport sink   (input valid, input route_dir, input hop_distance, output ready);
endinterface

>>> hdl/nrd_divider.sv
// Restoring divider, one quotient bit per stage, two lanes (current, target).
// Each stage also folds the new quotient bit into a running remainder of the
// quotient itself, so the torus Y coordinate mod side falls out at the end.
module nrd_divider import nrd_pkg::*; #(
    parameter int ID_BITS = NODE_ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [SIDE_BITS-1:0]          side,
    input  logic                          feed_valid,
    output logic                          feed_ready,
    input  logic [1:0][ID_BITS-1:0]       dividend,
    output logic                          done_valid,
    input  logic                          done_ready,
    output logic [1:0][ID_BITS-1:0]       quot,
    output logic [1:0][SIDE_BITS-1:0]     rem,
    output logic [1:0][SIDE_BITS-1:0]     qmod
);

    logic [ID_BITS-1:0] valid_reg;
    logic [ID_BITS-1:0] valid_src;
    logic [ID_BITS-1:0] en;

    logic [1:0][ID_BITS-1:0]   dvd_reg  [ID_BITS];
    logic [1:0][ID_BITS-1:0]   quot_reg [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] rem_reg  [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] qmod_reg [ID_BITS];

    logic [1:0][ID_BITS-1:0]   dvd_src  [ID_BITS];
    logic [1:0][ID_BITS-1:0]   quot_src [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] rem_src  [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] qmod_src [ID_BITS];

    logic [1:0][ID_BITS-1:0]   dvd_next  [ID_BITS];
    logic [1:0][ID_BITS-1:0]   quot_next [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] rem_next  [ID_BITS];
    logic [1:0][SIDE_BITS-1:0] qmod_next [ID_BITS];

    // Shift one bit into a partial remainder and take off the divisor if it fits.
    // Result is {quotient bit, new remainder}.
    function automatic logic [SIDE_BITS:0] div_step(
        input logic [SIDE_BITS-1:0] r,
        input logic                 b,
        input logic [SIDE_BITS-1:0] d
    );
        logic [SIDE_BITS:0] t;
        logic [SIDE_BITS:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            div_step = {1'b1, diff[SIDE_BITS-1:0]};
        else
            div_step = {1'b0, t[SIDE_BITS-1:0]};
    endfunction

    // Feed each stage from the one before it
    assign valid_src = {valid_reg[ID_BITS-2:0], feed_valid};

    always_comb
    begin
        dvd_src[0]  = dividend;
        quot_src[0] = '0;
        rem_src[0]  = '0;
        qmod_src[0] = '0;
        for (int s = 1; s < ID_BITS; s++)
        begin
            dvd_src[s]  = dvd_reg[s-1];
            quot_src[s] = quot_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            qmod_src[s] = qmod_reg[s-1];
        end
    end

    // One quotient bit per stage, then fold it into the quotient remainder
    always_comb
    begin
        logic [SIDE_BITS:0] qstep;
        logic [SIDE_BITS:0] mstep;
        for (int s = 0; s < ID_BITS; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                qstep = div_step(rem_src[s][l], dvd_src[s][l][ID_BITS-1], side);
                mstep = div_step(qmod_src[s][l], qstep[SIDE_BITS], side);
                rem_next[s][l]  = qstep[SIDE_BITS-1:0];
                qmod_next[s][l] = mstep[SIDE_BITS-1:0];
                quot_next[s][l] = {quot_src[s][l][ID_BITS-2:0], qstep[SIDE_BITS]};
                dvd_next[s][l]  = {dvd_src[s][l][ID_BITS-2:0], 1'b0};
            end
        end
    end

    // A stage moves when it or some later stage is empty, or the output word is taken
    always_comb
    begin
        for (int s = 0; s < ID_BITS; s++)
            en[s] = done_ready || (((~valid_reg) >> s) != '0);
    end

    assign feed_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < ID_BITS; s++)
                if (en[s])
                    valid_reg[s] <= valid_src[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ID_BITS; s++)
        begin
            if (en[s] && valid_src[s])
            begin
                dvd_reg[s]  <= dvd_next[s];
                quot_reg[s] <= quot_next[s];
                rem_reg[s]  <= rem_next[s];
                qmod_reg[s] <= qmod_next[s];
            end
        end
    end

    assign done_valid = valid_reg[ID_BITS-1];
    assign quot       = quot_reg[ID_BITS-1];
    assign rem        = rem_reg[ID_BITS-1];
    assign qmod       = qmod_reg[ID_BITS-1];

endmodule

>>> hdl/nrd_route.sv
// Axis differences in the first stage, direction choice into the output register
module nrd_route import nrd_pkg::*; #(
    parameter int ID_BITS = NODE_ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [TOPO_BITS-1:0]      topology,
    input  logic [SIDE_BITS-1:0]      side,
    input  logic                      feed_valid,
    output logic                      feed_ready,
    input  logic [1:0][ID_BITS-1:0]   quot,
    input  logic [1:0][SIDE_BITS-1:0] rem,
    input  logic [1:0][SIDE_BITS-1:0] qmod,
    nrd_rsp_if.source                 rsp
);

    localparam int WIDE_BITS = (ID_BITS > HOP_BITS) ? ID_BITS : HOP_BITS;

    logic                 r1_valid_reg;
    logic [SIDE_BITS-1:0] dx_reg, dx_next;
    logic                 x_down_reg, x_down_next;
    logic [SIDE_BITS-1:0] dy_reg, dy_next;
    logic                 y_down_reg, y_down_next;
    logic [ID_BITS-1:0]   mdy_reg, mdy_next;
    logic                 my_down_reg, my_down_next;

    logic                 out_valid_reg;
    route_t               route_reg, route_next;

    logic                 en_r1;
    logic                 en_out;
    route_t               x_route;
    route_t               y_route;
    logic [WIDE_BITS-1:0] mdy_wide;

    // One ring axis: shorter way round, tie when twice the distance is the side
    function automatic route_t ring_axis(
        input logic [SIDE_BITS-1:0] d,
        input logic                 down,
        input logic [SIDE_BITS-1:0] sd,
        input dir_t                 down_dir,
        input dir_t                 up_dir,
        input dir_t                 tie_dir
    );
        route_t             r;
        logic [SIDE_BITS:0] d2;
        d2 = {d, 1'b0};
        if (d == '0)
        begin
            r.dir  = DIR_ARRIVED;
            r.hops = '0;
        end
        else if (d2 < {1'b0, sd})
        begin
            r.dir  = down ? down_dir : up_dir;
            r.hops = d;
        end
        else if (d2 > {1'b0, sd})
        begin
            r.dir  = down ? up_dir : down_dir;
            r.hops = sd - d;
        end
        else
        begin
            r.dir  = tie_dir;
            r.hops = d;
        end
        return r;
    endfunction

    // Advance when the next stage has room
    assign en_out     = !out_valid_reg || rsp.ready;
    assign en_r1      = !r1_valid_reg || en_out;
    assign feed_ready = en_r1;

    // Absolute differences and signs per axis
    always_comb
    begin
        x_down_next  = rem[1] < rem[0];
        dx_next      = x_down_next ? (rem[0] - rem[1]) : (rem[1] - rem[0]);
        y_down_next  = qmod[1] < qmod[0];
        dy_next      = y_down_next ? (qmod[0] - qmod[1]) : (qmod[1] - qmod[0]);
        my_down_next = quot[1] < quot[0];
        mdy_next     = my_down_next ? (quot[0] - quot[1]) : (quot[1] - quot[0]);
    end

    // Pick the direction for the configured topology
    always_comb
    begin
        x_route  = ring_axis(dx_reg, x_down_reg, side, DIR_LEFT, DIR_RIGHT, DIR_ANY_X);
        y_route  = ring_axis(dy_reg, y_down_reg, side, DIR_BOTTOM, DIR_TOP, DIR_ANY_Y);
        mdy_wide = WIDE_BITS'(mdy_reg);
        route_next.dir  = DIR_ARRIVED;
        route_next.hops = '0;
        case (topo_t'(topology))
            TOPO_RING:
                route_next = x_route;
            TOPO_TORUS:
                route_next = (x_route.dir == DIR_ARRIVED) ? y_route : x_route;
            TOPO_MESH:
            begin
                if (dx_reg != '0)
                begin
                    route_next.dir  = x_down_reg ? DIR_LEFT : DIR_RIGHT;
                    route_next.hops = dx_reg;
                end
                else if (mdy_reg != '0)
                begin
                    route_next.dir  = my_down_reg ? DIR_BOTTOM : DIR_TOP;
                    route_next.hops = mdy_wide[HOP_BITS-1:0];
                end
            end
            default:
            begin
                route_next.dir  = DIR_ARRIVED;
                route_next.hops = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_r1)
                r1_valid_reg <= feed_valid;
            if (en_out)
                out_valid_reg <= r1_valid_reg;
        end
    end

    // Hold payload unless a new word moves in
    always_ff @(posedge clk)
    begin
        if (en_r1 && feed_valid)
        begin
            dx_reg      <= dx_next;
            x_down_reg  <= x_down_next;
            dy_reg      <= dy_next;
            y_down_reg  <= y_down_next;
            mdy_reg     <= mdy_next;
            my_down_reg <= my_down_next;
        end
        if (en_out && r1_valid_reg)
            route_reg <= route_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.route_dir    = route_reg.dir;
    assign rsp.hop_distance = route_reg.hops;

endmodule

>>> hdl/noc_route_direction_core.sv
// Route computation for one network-on-chip hop.
// req carries a current and a target node id; rsp returns the output direction
// and the hops left along the chosen axis, one response word per request word,
// in order. Both channels use a valid/ready handshake.
// cfg_wr_en writes cfg_data into the register picked by cfg_index: topology
// (ring, torus or mesh) and side_nodes. Write them only while no word is in
// flight.
// Pipeline: NODE_ID_BITS + 2 register stages (10 at the default id width): one
// divider stage per id bit, each a compare and subtract for the quotient bit and
// one more to fold it into the quotient remainder, then an axis-difference stage
// and the output register.
// Throughput: one word per cycle unless a stalled response has filled every stage.
// A stalled response holds in the output register; earlier stages keep filling
// their empty slots and req.ready drops only once every stage holds a word.
// Reset empties the pipeline and sets the mesh topology with a side of four.
module noc_route_direction_core import nrd_pkg::*; #(
    parameter int NODE_ID_BITS = NODE_ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    nrd_req_if.sink                   req,
    nrd_rsp_if.source                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [TOPO_BITS-1:0]          topology_reg;
    logic [SIDE_BITS-1:0]          side_reg;
    logic [SIDE_BITS-1:0]          side_eff;

    logic [1:0][NODE_ID_BITS-1:0]  dividend;
    logic                          div_valid;
    logic                          div_ready;
    logic [1:0][NODE_ID_BITS-1:0]  quot;
    logic [1:0][SIDE_BITS-1:0]     rem;
    logic [1:0][SIDE_BITS-1:0]     qmod;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= TOPO_RESET;
            side_reg     <= SIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOPOLOGY:   topology_reg <= cfg_data[TOPO_BITS-1:0];
                CFG_SIDE_NODES: side_reg     <= cfg_data[SIDE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Treat a zero side as one
    assign side_eff = (side_reg == '0) ? SIDE_BITS'(1) : side_reg;

    assign dividend[0] = req.current_node;
    assign dividend[1] = req.target_node;

    nrd_divider #(
        .ID_BITS (NODE_ID_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_eff),
        .feed_valid (req.valid),
        .feed_ready (req.ready),
        .dividend   (dividend),
        .done_valid (div_valid),
        .done_ready (div_ready),
        .quot       (quot),
        .rem        (rem),
        .qmod       (qmod)
    );

    nrd_route #(
        .ID_BITS (NODE_ID_BITS)
    ) u_route (
        .clk        (clk),
        .rst_n      (rst_n),
        .topology   (topology_reg),
        .side       (side_eff),
        .feed_valid (div_valid),
        .feed_ready (div_ready),
        .quot       (quot),
        .rem        (rem),
        .qmod       (qmod),
        .rsp        (rsp)
    );

`ifndef SYNTH
    // Arrival always reports no hops
    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.route_dir == DIR_ARRIVED |-> rsp.hop_distance == '0)
        else $error("arrived word with non-zero hop distance");

    // A mesh has no wraparound, so never a tie
    a_mesh_no_tie: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && topology_reg == TOPO_MESH
        |-> rsp.route_dir != DIR_ANY_X && rsp.route_dir != DIR_ANY_Y)
        else $error("tie direction reported in mesh");

    // A 1D ring only moves along X
    a_ring_x_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && topology_reg == TOPO_RING
        |-> rsp.route_dir != DIR_TOP && rsp.route_dir != DIR_BOTTOM
            && rsp.route_dir != DIR_ANY_Y)
        else $error("Y direction reported in 1D ring");

    // The shorter way round never exceeds half the side
    a_ring_half_side: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (topology_reg == TOPO_RING || topology_reg == TOPO_TORUS)
        |-> {rsp.hop_distance, 1'b0} <= {1'b0, side_eff})
        else $error("ring hop distance above half the side");
`endif

endmodule

>>> test/noc_route_direction_core_test.sv
module noc_route_direction_core_test import nrd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_BITS      = NODE_ID_BITS_DEF;
    localparam int LATENCY      = ID_BITS + 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SEGMENTS     = 4;
    localparam int SEGMENT_SIZE = 26;
    localparam int BURST_SIZE   = 60;

    // Spare topology code, routes nowhere
    localparam logic [TOPO_BITS-1:0] TOPO_SPARE = 2'd3;

    // One request word, optionally with its answer written out by hand
    typedef struct {
        logic [ID_BITS-1:0] cur;
        logic [ID_BITS-1:0] tgt;
        bit                 typed;
        route_t             answer;
    } hop_request_t;

    // Directed probe: setting, ids and, where obvious, the answer
    typedef struct {
        logic [TOPO_BITS-1:0] topo;
        logic [SIDE_BITS-1:0] side;
        logic [ID_BITS-1:0]   cur;
        logic [ID_BITS-1:0]   tgt;
        bit                   typed;
        dir_t                 dir;
        logic [HOP_BITS-1:0]  hops;
    } probe_t;

    localparam int PROBES = 24;

    probe_t probes [PROBES] = '{
        // straight after reset: mesh with a side of four
        '{TOPO_MESH,  8'd4,   8'd0,   8'd0,   1'b1, DIR_ARRIVED, 8'd0},
        '{TOPO_MESH,  8'd4,   8'd0,   8'd255, 1'b1, DIR_RIGHT,   8'd3},
        '{TOPO_MESH,  8'd4,   8'd255, 8'd0,   1'b1, DIR_LEFT,    8'd3},
        '{TOPO_MESH,  8'd4,   8'd0,   8'd252, 1'b1, DIR_TOP,     8'd63},
        '{TOPO_MESH,  8'd4,   8'd252, 8'd0,   1'b1, DIR_BOTTOM,  8'd63},
        // ring, even side: tie at half the ring, short way otherwise
        '{TOPO_RING,  8'd8,   8'd0,   8'd4,   1'b1, DIR_ANY_X,   8'd4},
        '{TOPO_RING,  8'd8,   8'd1,   8'd3,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_RING,  8'd8,   8'd1,   8'd7,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_RING,  8'd8,   8'd255, 8'd0,   1'b0, DIR_ARRIVED, 8'd0},
        // ring, odd side: never a tie
        '{TOPO_RING,  8'd7,   8'd0,   8'd3,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_RING,  8'd7,   8'd0,   8'd4,   1'b0, DIR_ARRIVED, 8'd0},
        // torus: ties per axis, Y growing is top
        '{TOPO_TORUS, 8'd4,   8'd0,   8'd2,   1'b1, DIR_ANY_X,   8'd2},
        '{TOPO_TORUS, 8'd4,   8'd0,   8'd8,   1'b1, DIR_ANY_Y,   8'd2},
        '{TOPO_TORUS, 8'd4,   8'd0,   8'd4,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_TORUS, 8'd4,   8'd4,   8'd0,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_TORUS, 8'd4,   8'd0,   8'd255, 1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_TORUS, 8'd4,   8'd3,   8'd252, 1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_TORUS, 8'd2,   8'd0,   8'd1,   1'b0, DIR_ARRIVED, 8'd0},
        '{TOPO_TORUS, 8'd16,  8'd0,   8'd255, 1'b0, DIR_ARRIVED, 8'd0},
        // zero side behaves as one: everything has arrived
        '{TOPO_RING,  8'd0,   8'd255, 8'd0,   1'b1, DIR_ARRIVED, 8'd0},
        // mesh of side one: Y is the whole id, no wraparound
        '{TOPO_MESH,  8'd1,   8'd0,   8'd255, 1'b1, DIR_TOP,     8'd255},
        '{TOPO_MESH,  8'd16,  8'd255, 8'd0,   1'b0, DIR_ARRIVED, 8'd0},
        // largest ring
        '{TOPO_RING,  8'd255, 8'd0,   8'd254, 1'b0, DIR_ARRIVED, 8'd0},
        // spare topology code
        '{TOPO_SPARE, 8'd16,  8'd0,   8'd255, 1'b1, DIR_ARRIVED, 8'd0}
    };

    logic clk;
    logic rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    nrd_req_if #(.ID_BITS(ID_BITS)) req_bus ();
    nrd_rsp_if                      rsp_bus ();

    noc_route_direction_core #(.NODE_ID_BITS(ID_BITS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the routing registers
    logic [TOPO_BITS-1:0] topo_reg = TOPO_RESET;
    logic [SIDE_BITS-1:0] side_reg = SIDE_RESET;

    hop_request_t words_waiting [$];
    hop_request_t offered_word;
    route_t       routes_due [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    bit  pressure_go   = 1'b0;
    logic rx_hold      = 1'b0;

    // One wraparound axis: a is where the packet is, b where it goes
    function automatic route_t wrap_axis(input int unsigned a, b, side,
                                         input dir_t down_dir, up_dir, tie_dir);
        int unsigned d;
        route_t      r;
        d = (a > b) ? a - b : b - a;
        r.dir  = DIR_ARRIVED;
        r.hops = '0;
        if (d != 0) begin
            if (2 * d < side) begin
                r.hops = HOP_BITS'(d);
                r.dir  = (b < a) ? down_dir : up_dir;
            end else if (2 * d > side) begin
                r.hops = HOP_BITS'(side - d);
                r.dir  = (b < a) ? up_dir : down_dir;
            end else begin
                r.hops = HOP_BITS'(d);
                r.dir  = tie_dir;
            end
        end
        return r;
    endfunction

    // Direction and hops left for one word under the given setting
    function automatic route_t predict_route(input logic [TOPO_BITS-1:0] topo,
                                             input logic [SIDE_BITS-1:0] side_val,
                                             input logic [ID_BITS-1:0] cur,
                                             input logic [ID_BITS-1:0] tgt);
        int unsigned side, cx, cy, tx, ty;
        route_t      r;
        side = (side_val == '0) ? 1 : int'(side_val);
        cx = cur % side;
        cy = cur / side;
        tx = tgt % side;
        ty = tgt / side;
        r.dir  = DIR_ARRIVED;
        r.hops = '0;
        case (topo)
            TOPO_RING:
                r = wrap_axis(cx, tx, side, DIR_LEFT, DIR_RIGHT, DIR_ANY_X);
            TOPO_TORUS:
            begin
                r = wrap_axis(cx, tx, side, DIR_LEFT, DIR_RIGHT, DIR_ANY_X);
                if (r.dir == DIR_ARRIVED)
                    r = wrap_axis(cy % side, ty % side, side,
                                  DIR_BOTTOM, DIR_TOP, DIR_ANY_Y);
            end
            TOPO_MESH:
            begin
                if (tx > cx) begin
                    r.dir  = DIR_RIGHT;
                    r.hops = HOP_BITS'(tx - cx);
                end else if (tx < cx) begin
                    r.dir  = DIR_LEFT;
                    r.hops = HOP_BITS'(cx - tx);
                end else if (ty > cy) begin
                    r.dir  = DIR_TOP;
                    r.hops = HOP_BITS'(ty - cy);
                end else if (ty < cy) begin
                    r.dir  = DIR_BOTTOM;
                    r.hops = HOP_BITS'(cy - ty);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Request side: hold an offered word until taken, predict on acceptance
    always @(posedge clk)
    begin : req_driver
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                if (offered_word.typed)
                    routes_due.push_back(offered_word.answer);
                else
                    routes_due.push_back(predict_route(topo_reg, side_reg,
                                                       req_bus.current_node,
                                                       req_bus.target_node));
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (words_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_word = words_waiting.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.current_node <= offered_word.cur;
                    req_bus.target_node  <= offered_word.tgt;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Response side: compare each word with the oldest prediction
    always @(posedge clk)
    begin : rsp_checker
        route_t due;
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (routes_due.size() == 0) begin
                    $display("%0t unexpected response word: dir %0d dist %0d",
                             $time, rsp_bus.route_dir, rsp_bus.hop_distance);
                    mismatches++;
                end else begin
                    due = routes_due.pop_front();
                    if (rsp_bus.route_dir !== due.dir) begin
                        $display("%0t route_dir mismatch: expected %0d actual %0d",
                                 $time, due.dir, rsp_bus.route_dir);
                        mismatches++;
                    end
                    if (rsp_bus.hop_distance !== due.hops) begin
                        $display("%0t hop_distance mismatch: expected %0d actual %0d",
                                 $time, due.hops, rsp_bus.hop_distance);
                        mismatches++;
                    end
                end
            end
            rsp_bus.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin : rx_hold_off
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin : watchdog
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
            $display("noc_route_direction_core_test NOT OK");
            $finish;
        end
    end

    // Wait until every word is answered, then let the pipeline settle
    task automatic drain_pipeline();
        @(negedge clk);
        while (words_waiting.size() != 0 || req_bus.valid || routes_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Write both routing registers; only called with the pipeline empty
    task automatic set_routing(input logic [TOPO_BITS-1:0] topo,
                               input logic [SIDE_BITS-1:0] side);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TOPOLOGY;
        cfg_data  <= CFG_DATA_BITS'(topo);
        topo_reg   = topo;
        @(posedge clk);
        cfg_index <= CFG_SIDE_NODES;
        cfg_data  <= side;
        side_reg   = side;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Pick a random setting, the unusual codes and sizes now and then
    task automatic pick_setting();
        logic [TOPO_BITS-1:0] topo;
        logic [SIDE_BITS-1:0] side;
        int unsigned          pick;
        pick = $urandom_range(9);
        topo = (pick < 3) ? TOPO_RING : (pick < 6) ? TOPO_TORUS :
               (pick < 9) ? TOPO_MESH : TOPO_SPARE;
        case ($urandom_range(9))
            0: side = SIDE_BITS'($urandom_range(1));
            1: side = 8'd2;
            2: side = 8'd255;
            3: side = 8'd16;
            default:
                side = (topo == TOPO_RING) ? SIDE_BITS'($urandom_range(255, 2))
                                           : SIDE_BITS'($urandom_range(16, 2));
        endcase
        set_routing(topo, side);
    endtask

    // Queue random words, some inside the current grid and most anywhere in the id range
    task automatic queue_random_words(input int count);
        hop_request_t w;
        int unsigned  side, span;
        side = (side_reg == '0) ? 1 : int'(side_reg);
        span = (topo_reg == TOPO_RING) ? side : side * side;
        if (span > 256)
            span = 256;
        w.typed  = 1'b0;
        w.answer = '0;
        repeat (count) begin
            case ($urandom_range(9))
                0:
                begin
                    w.cur = ID_BITS'($urandom_range(255));
                    w.tgt = w.cur;
                end
                1, 2, 3, 4:
                begin
                    w.cur = ID_BITS'($urandom_range(span - 1));
                    w.tgt = ID_BITS'($urandom_range(span - 1));
                end
                default:
                begin
                    w.cur = ID_BITS'($urandom_range(255));
                    w.tgt = ID_BITS'($urandom_range(255));
                end
            endcase
            words_waiting.push_back(w);
        end
    endtask

    initial
    begin : main
        hop_request_t w;
        int           phase;
        int           seg;
        req_bus.valid        = 1'b0;
        req_bus.current_node = '0;
        req_bus.target_node  = '0;
        rsp_bus.ready        = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = CFG_TOPOLOGY;
        cfg_data             = '0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed probes, settings changed only with the pipeline empty
        send_idle_pct = 27;
        recv_idle_pct = 50;
        foreach (probes[i]) begin
            if (probes[i].topo != topo_reg || probes[i].side != side_reg) begin
                drain_pipeline();
                set_routing(probes[i].topo, probes[i].side);
            end
            w.cur         = probes[i].cur;
            w.tgt         = probes[i].tgt;
            w.typed       = probes[i].typed;
            w.answer.dir  = probes[i].dir;
            w.answer.hops = probes[i].hops;
            words_waiting.push_back(w);
        end

        // Random words in three idling phases, several settings each
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct = 27;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                drain_pipeline();
                if (seg == 0) begin
                    case (phase)
                        0:       set_routing(TOPO_RING, 8'd255);
                        1:       set_routing(TOPO_MESH, 8'd16);
                        default: set_routing(TOPO_TORUS, 8'd2);
                    endcase
                end else begin
                    pick_setting();
                end
                queue_random_words(SEGMENT_SIZE);
                // Fill the pipeline against a stalled receiver
                if (phase == 2 && seg == 1) begin
                    pressure_go = 1'b1;
                    queue_random_words(BURST_SIZE);
                end
            end
        end

        drain_pipeline();
        if (mismatches == 0)
            $display("noc_route_direction_core_test OK");
        else
            $display("noc_route_direction_core_test NOT OK");
        $finish;
    end

endmodule
